// File: src/mlp_pkg.sv
// Package: shared types, constants and helpers for the MLP inference unit.
`timescale 1ns / 1ps
package mlp_pkg;
    localparam int MAX_LAYERS = 4;
    localparam int MAX_WIDTH  = 16;
    localparam int FRAC_BITS  = 8;
    localparam int COLS       = MAX_WIDTH + 1;
    localparam int W_DEPTH    = MAX_LAYERS * MAX_WIDTH * COLS;
    localparam int W_AW       = $clog2(W_DEPTH);
    localparam int A_DEPTH    = 2 * COLS;
    localparam int A_AW       = $clog2(A_DEPTH);
    localparam int LAY_W      = 2;
    localparam int ROW_W      = 4;
    localparam int POS_W      = 5;
    localparam int CNT_W      = 5;
    localparam int ACC_W      = 48;
    localparam logic signed [15:0] ONE_Q = 16'sd256;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_INPUT  = 2'd1,
        OP_RUN    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_LAYERS = 3'd0,
        CFG_INPUTS = 3'd1,
        CFG_ROWS0  = 3'd2,
        CFG_ROWS1  = 3'd3,
        CFG_ROWS2  = 3'd4,
        CFG_ROWS3  = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_MAC,
        ST_DRAIN,
        ST_WB,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]        op;
        logic [LAY_W-1:0]  layer;
        logic [ROW_W-1:0]  row;
        logic [POS_W-1:0]  position;
        logic signed [15:0] value;
    } t_req;

    typedef struct packed {
        logic [ROW_W-1:0]   out_index;
        logic signed [15:0] out_value;
        logic               last;
    } t_res;

    function automatic logic [CNT_W-1:0] clamp_w(input logic [CNT_W-1:0] v);
        if (v == '0) return CNT_W'(1);
        if (v > CNT_W'(MAX_WIDTH)) return CNT_W'(MAX_WIDTH);
        return v;
    endfunction

    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] q;
        q = (acc + ACC_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (q > 32767) return 16'sh7fff;
        if (q < -32768) return -16'sh8000;
        return q[15:0];
    endfunction
endpackage

// File: src/mlp_stream_if.sv
// Interface: valid/ready channel carrying one payload.
`timescale 1ns / 1ps
interface mlp_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/mlp_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module mlp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: src/mlp_relu_forward_pass_unit.sv
// Top level: MLP inference unit with weight memory and activation memory.
// Load requests (weight or input writes) are accepted only while idle. A run
// first copies the bias and the inputs into the activation memory, then for
// each layer and neuron streams the weights through one multiply-accumulate
// fed by registered memory reads. Results leave through an output register;
// the unit accepts no new request until a run has delivered all results. The
// input store is a small register file reset to 1.0.
`timescale 1ns / 1ps
module mlp_relu_forward_pass_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [4:0]        i_cfg_data,
    mlp_stream_if.sink        in_req,
    mlp_stream_if.source      out_res
);
    import mlp_pkg::*;

    t_state r_state, n_state;
    logic [2:0]        r_layer_count;
    logic [CNT_W-1:0]  r_input_count;
    logic [CNT_W-1:0]  r_rows [MAX_LAYERS];
    logic signed [15:0] r_inp [MAX_WIDTH];

    logic [LAY_W-1:0]  r_l, n_l;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [CNT_W-1:0]  r_ncols, n_ncols;
    logic              r_src, n_src;
    logic              r_mv, n_mv;
    logic signed [31:0] r_prod;
    logic              r_pv;
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [2:0]        r_pipe;
    logic              r_ov, n_ov;
    t_res              r_res, n_res;

    t_req  req;
    logic  acc_in;
    logic [2:0] nl;
    logic [CNT_W-1:0] nrows;
    logic  hidden;

    logic              w_we;
    logic [W_AW-1:0]   w_waddr, w_raddr;
    logic [15:0]       w_rdata;
    logic              a_we;
    logic [A_AW-1:0]   a_waddr, a_raddr;
    logic [15:0]       a_wdata, a_rdata;
    logic signed [15:0] nv;

    assign req    = in_req.data;
    assign in_req.ready = (r_state == ST_IDLE);
    assign acc_in = in_req.valid && in_req.ready;
    assign out_res.valid = r_ov;
    assign out_res.data  = r_res;

    assign nl = (r_layer_count == 3'd0) ? 3'd1 :
                (r_layer_count > 3'(MAX_LAYERS)) ? 3'(MAX_LAYERS) : r_layer_count;
    assign nrows  = clamp_w(r_rows[r_l]);
    assign hidden = (3'(r_l) + 3'd1) < nl;

    mlp_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_wmem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(req.value),
        .i_raddr(w_raddr), .o_rdata(w_rdata));
    mlp_ram #(.WIDTH(16), .DEPTH(A_DEPTH)) u_amem (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(a_raddr), .o_rdata(a_rdata));

    assign w_we = acc_in && (req.op == OP_WEIGHT) && (req.position <= POS_W'(MAX_WIDTH));
    assign w_waddr = W_AW'((32'(req.layer) * MAX_WIDTH + 32'(req.row)) * COLS
                           + 32'(req.position));
    assign w_raddr = W_AW'((32'(r_l) * MAX_WIDTH + 32'(r_i)) * COLS + 32'(r_j));
    assign a_raddr = A_AW'((r_src ? COLS : 0) + 32'(r_j));
    assign nv = round_sat(r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count <= 3'd1;
            r_input_count <= CNT_W'(16);
            for (int k = 0; k < MAX_LAYERS; k++) r_rows[k] <= CNT_W'(16);
            for (int k = 0; k < MAX_WIDTH; k++) r_inp[k] <= ONE_Q;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_LAYERS: r_layer_count <= i_cfg_data[2:0];
                    CFG_INPUTS: r_input_count <= i_cfg_data;
                    CFG_ROWS0:  r_rows[0] <= i_cfg_data;
                    CFG_ROWS1:  r_rows[1] <= i_cfg_data;
                    CFG_ROWS2:  r_rows[2] <= i_cfg_data;
                    CFG_ROWS3:  r_rows[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (acc_in && req.op == OP_INPUT && req.position < POS_W'(MAX_WIDTH))
                r_inp[req.position[ROW_W-1:0]] <= req.value;
        end
    end

    always_comb begin
        n_state = r_state; n_l = r_l; n_i = r_i; n_j = r_j; n_ncols = r_ncols;
        n_src = r_src; n_mv = 1'b0; n_acc = r_acc; n_ov = r_ov; n_res = r_res;
        a_we = 1'b0; a_waddr = '0; a_wdata = '0;
        if (r_pv) n_acc = r_acc + ACC_W'(r_prod);
        unique case (r_state)
            ST_IDLE: begin
                if (acc_in && req.op == OP_RUN) begin
                    n_state = ST_COPY; n_j = '0; n_src = 1'b0; n_l = '0;
                    n_ncols = clamp_w(r_input_count) + CNT_W'(1);
                end
            end
            ST_COPY: begin
                a_we = 1'b1; a_waddr = A_AW'(r_j);
                a_wdata = (r_j == '0) ? ONE_Q : r_inp[4'(r_j - CNT_W'(1))];
                if (r_j + CNT_W'(1) == r_ncols) begin
                    n_state = ST_MAC; n_i = '0; n_j = '0; n_acc = '0;
                end else n_j = r_j + CNT_W'(1);
            end
            ST_MAC: begin
                n_mv = 1'b1;
                if (r_j + CNT_W'(1) == r_ncols) n_state = ST_DRAIN;
                else n_j = r_j + CNT_W'(1);
            end
            ST_DRAIN: begin
                // set the bias slot of the destination bank
                a_we = 1'b1; a_waddr = A_AW'(r_src ? 0 : COLS); a_wdata = ONE_Q;
                if (r_pipe == '0 && !r_pv) n_state = ST_WB;
            end
            ST_WB: begin
                a_we = 1'b1;
                a_waddr = A_AW'((r_src ? 0 : COLS) + 32'(r_i) + 1);
                a_wdata = (hidden && nv < 0) ? 16'sd0 : nv;
                if (!hidden) begin
                    n_ov = 1'b1;
                    n_res.out_index = r_i[ROW_W-1:0];
                    n_res.out_value = nv;
                    n_res.last = (r_i + CNT_W'(1) == nrows);
                    n_state = ST_EMIT;
                end else if (r_i + CNT_W'(1) == nrows) begin
                    a_we = 1'b1;
                    n_state = ST_MAC; n_l = r_l + LAY_W'(1); n_i = '0; n_j = '0;
                    n_acc = '0; n_src = !r_src; n_ncols = nrows + CNT_W'(1);
                end else begin
                    n_state = ST_MAC; n_i = r_i + CNT_W'(1); n_j = '0; n_acc = '0;
                end
            end
            ST_EMIT: begin
                if (out_res.ready) begin
                    n_ov = 1'b0;
                    if (r_res.last) n_state = ST_IDLE;
                    else begin
                        n_state = ST_MAC; n_i = r_i + CNT_W'(1); n_j = '0; n_acc = '0;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE; r_ov <= 1'b0; r_mv <= 1'b0; r_pv <= 1'b0;
            r_pipe <= '0;
        end else begin
            r_state <= n_state; r_ov <= n_ov; r_mv <= n_mv; r_pv <= r_mv;
            r_pipe <= {r_pipe[1:0], n_mv};
        end
        r_l <= n_l; r_i <= n_i; r_j <= n_j; r_ncols <= n_ncols; r_src <= n_src;
        r_acc <= n_acc; r_res <= n_res;
        r_prod <= $signed(w_rdata) * $signed(a_rdata);
    end

`ifndef SYNTH
    a_no_out_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_ov) else $error("result valid while idle");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_req.ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !out_res.ready |=> $stable(r_res)) else $error("result changed");
`endif
endmodule
